/* src/ddo_pkg.sv */
// Shared types, constants and tables for the differential-drive odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int CFG_W          = 24;
    localparam int IN_W           = 96;
    localparam int OUT_W          = 144;
    localparam int ATAN_COUNT     = 24;
    localparam int ATAN_IDX_W     = 5;
    localparam int CORDIC_W       = 34;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int POS_WIDTH_DEF    = 32;

    localparam logic [CFG_W-1:0] DPC_RESET  = 24'd14118;
    localparam logic [CFG_W-1:0] GAIN_RESET = 24'd12145;
    localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

    typedef enum logic [0:0] {
        CFG_DPC  = 1'b0,
        CFG_GAIN = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_TRAV = 2'd0,
        MUL_HEAD = 2'd1,
        MUL_DX   = 2'd2,
        MUL_DY   = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic                  load;
        logic                  cord_step;
        logic [ATAN_IDX_W-1:0] step_idx;
        logic                  cord_fix;
        t_mul_sel              mul_sel;
        logic                  upd_trav;
        logic                  upd_head;
        logic                  upd_x;
        logic                  upd_y;
        logic                  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* src/ddo_ctrl.sv */
// Sequencer for the odometry update: CORDIC steps, multiplies, accumulate, output.
`timescale 1ns / 1ps
module ddo_ctrl
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int N_STEPS = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
    localparam int CNT_W   = (N_STEPS > 1) ? $clog2(N_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CORD  = 9'b000000010,
        S_FIX   = 9'b000000100,
        S_MTRAV = 9'b000001000,
        S_MHEAD = 9'b000010000,
        S_MDX   = 9'b000100000,
        S_MDY   = 9'b001000000,
        S_YUPD  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step_idx = ATAN_IDX_W'(r_cnt);
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_CORD;
                end
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.cord_fix = 1'b1;
                n_state = S_MTRAV;
            end
            S_MTRAV: begin
                o_cmd.mul_sel = MUL_TRAV;
                n_state = S_MHEAD;
            end
            S_MHEAD: begin
                o_cmd.mul_sel  = MUL_HEAD;
                o_cmd.upd_trav = 1'b1;
                n_state = S_MDX;
            end
            S_MDX: begin
                o_cmd.mul_sel  = MUL_DX;
                o_cmd.upd_head = 1'b1;
                n_state = S_MDY;
            end
            S_MDY: begin
                o_cmd.mul_sel = MUL_DY;
                o_cmd.upd_x   = 1'b1;
                n_state = S_YUPD;
            end
            S_YUPD: begin
                o_cmd.upd_y = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* src/ddo_dp.sv */
// Datapath: config registers, CORDIC stage, shared multiplier, pose accumulators, output buffer.
`timescale 1ns / 1ps
module ddo_dp
    import ddo_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [0:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic [IN_W-1:0]  i_in_data,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int DX_W = PROD_W - 30;
    localparam int SW   = ((POS_WIDTH > DX_W) ? POS_WIDTH : DX_W) + 1;
    localparam int OW   = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam logic signed [SW-1:0] P_MAX = {{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] P_MIN = {{(SW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [OW-1:0] O_MAX = {{(OW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [OW-1:0] O_MIN = {{(OW-31){1'b1}}, {31{1'b0}}};

    logic [CFG_W-1:0] r_dpc, r_gain;
    logic signed [POS_WIDTH-1:0] r_x, r_y, n_x, n_y;
    logic [23:0] r_heading;
    logic signed [15:0] r_left, r_right;
    logic [63:0] r_stamp;
    logic signed [CORDIC_W-1:0] r_cx, r_cy, r_cz;
    logic r_flip;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [31:0] r_travel;
    logic r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpc  <= DPC_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_DPC:  r_dpc  <= i_cfg_wdata;
                CFG_GAIN: r_gain <= i_cfg_wdata;
                default:  r_dpc  <= r_dpc;
            endcase
        end
    end

    // CORDIC
    logic        w_flip;
    logic [31:0] w_turns;
    logic signed [CORDIC_W-1:0] w_xs, w_ys, w_atan;

    assign w_flip  = r_heading[23] ^ r_heading[22];
    assign w_turns = {r_heading[23] ^ w_flip, r_heading[22:0], 8'h00};
    assign w_xs    = r_cx >>> i_cmd.step_idx;
    assign w_ys    = r_cy >>> i_cmd.step_idx;
    assign w_atan  = $signed({{(CORDIC_W-32){1'b0}}, atan_turn(i_cmd.step_idx)});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_left  <= $signed(i_in_data[15:0]);
            r_right <= $signed(i_in_data[31:16]);
            r_stamp <= i_in_data[95:32];
            r_cx    <= CORDIC_INV_GAIN;
            r_cy    <= '0;
            r_cz    <= $signed({{(CORDIC_W-32){w_turns[31]}}, w_turns});
            r_flip  <= w_flip;
        end else if (i_cmd.cord_step) begin
            if (!r_cz[CORDIC_W-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end
        end else if (i_cmd.cord_fix && r_flip) begin
            r_cx <= -r_cx;
            r_cy <= -r_cy;
        end
    end

    // shared multiplier
    logic signed [16:0] w_sum, w_diff;
    logic signed [MUL_W-1:0] w_ma, w_mb;

    assign w_sum  = 17'(r_left) + 17'(r_right);
    assign w_diff = 17'(r_right) - 17'(r_left);

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_TRAV: begin
                w_ma = MUL_W'(w_sum);
                w_mb = $signed({{(MUL_W-CFG_W){1'b0}}, r_dpc});
            end
            MUL_HEAD: begin
                w_ma = MUL_W'(w_diff);
                w_mb = $signed({{(MUL_W-CFG_W){1'b0}}, r_gain});
            end
            MUL_DX: begin
                w_ma = MUL_W'(r_travel);
                w_mb = r_cx[MUL_W-1:0];
            end
            MUL_DY: begin
                w_ma = MUL_W'(r_travel);
                w_mb = r_cy[MUL_W-1:0];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // travel, heading, position
    logic [40:0] w_trav_sum;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [DX_W-1:0] w_delta;
    logic signed [SW-1:0] w_xsum, w_ysum;

    assign w_trav_sum = r_prod[40:0] + 41'd256;
    assign w_rnd      = r_prod + PROD_W'(64'd536870912);
    assign w_delta    = w_rnd[PROD_W-1:30];
    assign w_xsum     = SW'(r_x) + SW'(w_delta);
    assign w_ysum     = SW'(r_y) + SW'(w_delta);

    always_comb begin
        if (w_xsum > P_MAX) begin
            n_x = P_MAX[POS_WIDTH-1:0];
        end else if (w_xsum < P_MIN) begin
            n_x = P_MIN[POS_WIDTH-1:0];
        end else begin
            n_x = w_xsum[POS_WIDTH-1:0];
        end
        if (w_ysum > P_MAX) begin
            n_y = P_MAX[POS_WIDTH-1:0];
        end else if (w_ysum < P_MIN) begin
            n_y = P_MIN[POS_WIDTH-1:0];
        end else begin
            n_y = w_ysum[POS_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_trav) begin
            r_travel <= $signed(w_trav_sum[40:9]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_heading <= '0;
        end else begin
            if (i_cmd.upd_head) begin
                r_heading <= r_heading + r_prod[23:0];
            end
            if (i_cmd.upd_x) begin
                r_x <= n_x;
            end
            if (i_cmd.upd_y) begin
                r_y <= n_y;
            end
        end
    end

    // output buffer
    logic signed [OW-1:0] w_xo, w_yo;
    logic [31:0] w_xc, w_yc;

    assign w_xo = OW'(r_x);
    assign w_yo = OW'(r_y);
    assign w_xc = (w_xo > O_MAX) ? 32'h7FFFFFFF : (w_xo < O_MIN) ? 32'h80000000 : w_xo[31:0];
    assign w_yc = (w_yo > O_MAX) ? 32'h7FFFFFFF : (w_yo < O_MIN) ? 32'h80000000 : w_yo[31:0];

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_stamp, r_heading[23:8], w_yc, w_xc};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/diff_drive_odometry_top.sv */
// Top level of the differential-drive wheel odometry block.
//
//  channel  | dir | fields (lowest bit up)
//  s_axis   | in  | tdata: left_ticks[15:0], right_ticks[31:16], time_stamp[95:32]
//  m_axis   | out | tdata: pos_x[31:0], pos_y[63:32], heading_angle[79:64], stamp_out[143:80]
//  cfg      | in  | i_cfg_addr 0 = distance_per_count, 1 = heading_gain
//
// One request passes through the single iterative CORDIC stage and the one shared multiplier
// doing four products in turn; s_axis_tready stays low until it is loaded into the output buffer.
// Reset clears the pose and loads the register defaults.
// A finished pose waits in the output buffer; the next request is taken meanwhile
// and only its final load stalls on a full buffer.
`timescale 1ns / 1ps
module diff_drive_odometry_top
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [0:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // left_ticks, right_ticks, time_stamp
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // pos_x, pos_y, heading_angle, stamp_out
);

    t_cmd    w_cmd;
    t_status w_status;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ddo_dp #(
        .POS_WIDTH(POS_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* sim/diff_drive_odometry_checker.sv */
// Checker for the odometry block: tracks the pose on its own and compares every output pose.
`timescale 1ns / 1ps
module diff_drive_odometry_checker
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [0:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic [IN_W-1:0]  i_req_data,    // left_ticks, right_ticks, time_stamp
    input  logic             i_pose_valid,
    input  logic             i_pose_ready,
    input  logic [OUT_W-1:0] i_pose_data,   // pos_x, pos_y, heading_angle, stamp_out
    output int               o_mismatch_count,
    output int               o_poses_pending
);

    typedef struct packed {
        logic [63:0] stamp;
        logic [15:0] right;
        logic [15:0] left;
    } t_tick_report;

    typedef struct packed {
        logic [63:0] stamp;
        logic [15:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_pose;

    localparam int STEPS_USED = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;

    // atan(2^-i) in 2^-32 turn units, entry 0 in the lowest word
    localparam logic [ATAN_COUNT*32-1:0] ATAN_TABLE = {
        32'h00000051, 32'h000000A2, 32'h00000145, 32'h0000028B,
        32'h00000517, 32'h00000A2F, 32'h0000145F, 32'h000028BE,
        32'h0000517C, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
        32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
        32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
        32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
    };

    logic [CFG_W-1:0] dist_per_count;
    logic [CFG_W-1:0] turn_gain;
    longint           x_pos;
    longint           y_pos;
    logic [23:0]      heading_q8;
    t_pose            expected_poses[$];
    int               mismatches;
    int               poses_seen;

    function automatic longint saturate(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // rotation-mode CORDIC; the left half plane is folded over by half a turn
    function automatic void heading_cos_sin(input logic [31:0] turns,
                                            output longint c, output longint s);
        logic        flip;
        logic [31:0] t;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        int          i;
        flip = (turns[31:30] == 2'd1) || (turns[31:30] == 2'd2);
        t = flip ? turns + 32'h8000_0000 : turns;
        z = longint'($signed(t));
        x = longint'(CORDIC_INV_GAIN);
        y = 0;
        for (i = 0; i < STEPS_USED; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_TABLE[i*32 +: 32]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_TABLE[i*32 +: 32]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic t_pose advance_pose(input t_tick_report req);
        longint travel;
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint diff;
        t_pose  p;
        travel = ((longint'($signed(req.left)) + longint'($signed(req.right)))
                  * longint'(dist_per_count) + 256) >>> 9;
        heading_cos_sin({heading_q8, 8'h00}, c, s);
        dx = (travel * c + (longint'(1) << 29)) >>> 30;
        dy = (travel * s + (longint'(1) << 29)) >>> 30;
        x_pos = saturate(x_pos + dx, POS_WIDTH);
        y_pos = saturate(y_pos + dy, POS_WIDTH);
        diff = longint'($signed(req.right)) - longint'($signed(req.left));
        heading_q8 = heading_q8 + 24'(diff * longint'(turn_gain));
        p.pos_x   = 32'(saturate(x_pos, 32));
        p.pos_y   = 32'(saturate(y_pos, 32));
        p.heading = heading_q8[23:8];
        p.stamp   = req.stamp;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: pose %0d mismatch: %s", $time, poses_seen, msg);
    endtask

    task automatic compare_pose(input t_pose got);
        t_pose want;
        if (expected_poses.size() == 0) begin
            report_mismatch($sformatf("unexpected pose %h", got));
            return;
        end
        want = expected_poses.pop_front();
        if (got.pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x %h, want %h", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y %h, want %h", got.pos_y, want.pos_y));
        if (got.heading !== want.heading)
            report_mismatch($sformatf("heading %h, want %h", got.heading, want.heading));
        if (got.stamp !== want.stamp)
            report_mismatch($sformatf("stamp %h, want %h", got.stamp, want.stamp));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dist_per_count = DPC_RESET;
            turn_gain      = GAIN_RESET;
            x_pos          = 0;
            y_pos          = 0;
            heading_q8     = '0;
            expected_poses.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_addr)
                    CFG_DPC:  dist_per_count = i_cfg_wdata;
                    CFG_GAIN: turn_gain = i_cfg_wdata;
                    default: ;
                endcase
            end
            // outputs first: a pose leaving now can never belong to a request taken now
            if (i_pose_valid && i_pose_ready) begin
                compare_pose(t_pose'(i_pose_data));
                poses_seen++;
            end
            if (i_req_valid && i_req_ready)
                expected_poses.push_back(advance_pose(t_tick_report'(i_req_data)));
        end
        o_mismatch_count <= mismatches;
        o_poses_pending  <= expected_poses.size();
    end

endmodule

/* sim/diff_drive_odometry_top_test.sv */
// Testbench top for the odometry block: clock, reset, tick reports, calibration and verdict.
`timescale 1ns / 1ps
module diff_drive_odometry_top_test;
    import ddo_pkg::*;

    localparam int LATENCY      = CORDIC_STEPS_DEF + 8;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 215;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wen = 1'b0;
    logic [0:0]       i_cfg_addr = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;   // left_ticks, right_ticks, time_stamp
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // pos_x, pos_y, heading_angle, stamp_out

    int               mismatch_count;
    int               poses_pending;
    int               sender_idle_pct = 7;
    int               receiver_stall_pct = 56;
    logic [63:0]      stamp_seq = 64'd1;

    always #2 i_clk = ~i_clk;

    diff_drive_odometry_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    diff_drive_odometry_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_valid      (s_axis_tvalid),
        .i_req_ready      (s_axis_tready),
        .i_req_data       (s_axis_tdata),
        .i_pose_valid     (m_axis_tvalid),
        .i_pose_ready     (m_axis_tready),
        .i_pose_data      (m_axis_tdata),
        .o_mismatch_count (mismatch_count),
        .o_poses_pending  (poses_pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_ticks(input logic [15:0] left, input logic [15:0] right,
                              input logic [63:0] stamp);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, right, left};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_counted(input logic [15:0] left, input logic [15:0] right);
        send_ticks(left, right, stamp_seq);
        stamp_seq = stamp_seq + 64'd1;
    endtask

    function automatic logic [15:0] tick_corner();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // mostly gentle driving and turning, with full-range and extreme reports mixed in
    task automatic send_random_report();
        int          pick;
        int          base;
        int          jitter_l;
        int          jitter_r;
        logic [15:0] left;
        logic [15:0] right;
        pick = $urandom_range(99);
        base = $urandom_range(600);
        base -= 300;
        jitter_l = $urandom_range(40);
        jitter_r = $urandom_range(40);
        if (pick < 55) begin
            left  = 16'(base + jitter_l - 20);
            right = 16'(base + jitter_r - 20);
        end else if (pick < 70) begin
            left  = 16'(-(base * 4) + jitter_l);
            right = 16'((base * 4) + jitter_r);
        end else if (pick < 90) begin
            left  = 16'($urandom);
            right = 16'($urandom);
        end else begin
            left  = tick_corner();
            right = tick_corner();
        end
        send_ticks(left, right, {$urandom, $urandom});
    endtask

    task automatic write_calibration(input logic [CFG_W-1:0] dpc,
                                     input logic [CFG_W-1:0] gain);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (poses_pending != 0) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= CFG_DPC;
        i_cfg_wdata <= dpc;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_GAIN;
        i_cfg_wdata <= gain;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        int phase;
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: quadrant sweep, heading wrap, extreme ticks and stamps
        send_ticks(16'd0, 16'd0, 64'd0);
        send_ticks(16'd100, 16'd100, 64'hFFFF_FFFF_FFFF_FFFF);
        send_counted(-16'sd200, 16'sd200);
        send_counted(16'd500, 16'd500);
        send_counted(-16'sd200, 16'sd200);
        send_counted(16'd500, 16'd500);
        send_counted(-16'sd200, 16'sd200);
        send_counted(16'd500, 16'd500);
        send_counted(16'h8000, 16'h7FFF);
        send_counted(16'h7FFF, 16'h8000);
        send_counted(16'h7FFF, 16'h7FFF);
        send_counted(16'h8000, 16'h8000);
        send_counted(16'hFFFF, 16'h0001);

        // largest travel per count drives the position into both rails
        write_calibration(24'hFFFFFF, GAIN_RESET);
        send_counted(16'h7FFF, 16'h7FFF);
        send_counted(16'h7FFF, 16'h7FFF);
        send_counted(16'h8000, 16'h8000);
        send_counted(16'h8000, 16'h8000);
        send_counted(16'h8000, 16'h8000);
        send_counted(16'd0, 16'd0);

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 2) begin
                sender_idle_pct    = 56;
                receiver_stall_pct = 7;
            end else if (phase == 4) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            case (phase)
                0:       write_calibration(DPC_RESET, GAIN_RESET);
                1:       write_calibration(24'hFFFFFF, 24'hFFFFFF);
                2:       write_calibration(24'd0, 24'd0);
                3:       write_calibration(24'($urandom), 24'($urandom));
                4:       write_calibration(24'($urandom_range(1, 65535)), 24'($urandom));
                default: write_calibration(24'd1, 24'($urandom_range(256, 65535)));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_report();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (poses_pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && poses_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
